>>> rtl/core/crd_pkg.sv
`timescale 1ns / 1ps

package crd_pkg;

  // Default geometry
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Capacity register
  localparam int              CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // APB port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register word index decoded from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_CAPACITY = 1'b0;

  // Command codes
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;  // run the accepted word: update pointers, write store
    logic load;  // capture the result into the output register
  } dp_cmd_t;

endpackage

>>> rtl/core/crd_ram.sv
`timescale 1ns / 1ps

module crd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads on two ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> rtl/core/crd_ctrl.sv
`timescale 1ns / 1ps

module crd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output crd_pkg::dp_cmd_t dp_cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequence one word: execute, read store, load result
  always_comb begin
    state_d       = state_q;
    dp_cmd_o.exec = 1'b0;
    dp_cmd_o.load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.exec = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          dp_cmd_o.load = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (dp_cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/crd_datapath.sv
`timescale 1ns / 1ps

module crd_datapath #(
  parameter int DEPTH      = crd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = crd_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crd_pkg::dp_cmd_t              dp_cmd_i,
  input  logic                          cfg_we_i,
  input  logic [crd_pkg::CAP_W-1:0]     cfg_cap_i,
  output logic [crd_pkg::CAP_W-1:0]     cap_o,
  input  logic [2:0]                    cmd_i,
  input  logic signed [DATA_WIDTH-1:0]  value_i,
  output logic                          ok_o,
  output logic signed [DATA_WIDTH-1:0]  front_value_o,
  output logic signed [DATA_WIDTH-1:0]  rear_value_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic [CNT_W-1:0]              count_o
);

  localparam int CAP_W = crd_pkg::CAP_W;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CAP_RST_I = int'(crd_pkg::CAP_RESET);
  localparam int EFF_RST   = (CAP_RST_I == 0) ? 1 :
                             ((CAP_RST_I > DEPTH) ? DEPTH : CAP_RST_I);

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] eff_cap_q, eff_cap_d;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ok_q, ok_d;

  logic [IDX_W-1:0] cap_last, head_inc, head_dec, tail_inc, tail_dec;
  logic             is_full_now, is_empty_now;
  logic [CMP_W-1:0] cfg_ext;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] rd_front, rd_rear;

  // Clamp a written capacity into 1..DEPTH
  assign cfg_ext = CMP_W'(cfg_cap_i);
  always_comb begin
    if (cfg_cap_i == '0) begin
      eff_cap_d = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(DEPTH)) begin
      eff_cap_d = CNT_W'(DEPTH);
    end else begin
      eff_cap_d = CNT_W'(cfg_ext);
    end
  end

  // Wrapping index neighbors
  assign cap_last     = IDX_W'(eff_cap_q - CNT_W'(1));
  assign head_inc     = (head_q == cap_last) ? '0 : head_q + IDX_W'(1);
  assign head_dec     = (head_q == '0) ? cap_last : head_q - IDX_W'(1);
  assign tail_inc     = (tail_q == cap_last) ? '0 : tail_q + IDX_W'(1);
  assign tail_dec     = (tail_q == '0) ? cap_last : tail_q - IDX_W'(1);
  assign is_full_now  = (count_q == eff_cap_q);
  assign is_empty_now = (count_q == '0);

  // Execute one command
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    ok_d      = ok_q;
    ram_we    = 1'b0;
    ram_waddr = tail_q;
    if (dp_cmd_i.exec) begin
      ok_d = 1'b1;
      case (cmd_i)
        crd_pkg::CMD_PUSH_FRONT: begin
          if (is_full_now) begin
            ok_d = 1'b0;
          end else begin
            head_d    = head_dec;
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            count_d   = count_q + CNT_W'(1);
          end
        end
        crd_pkg::CMD_PUSH_BACK: begin
          if (is_full_now) begin
            ok_d = 1'b0;
          end else begin
            tail_d    = tail_inc;
            ram_we    = 1'b1;
            ram_waddr = tail_q;
            count_d   = count_q + CNT_W'(1);
          end
        end
        crd_pkg::CMD_POP_FRONT: begin
          if (is_empty_now) begin
            ok_d = 1'b0;
          end else begin
            head_d  = head_inc;
            count_d = count_q - CNT_W'(1);
          end
        end
        crd_pkg::CMD_POP_BACK: begin
          if (is_empty_now) begin
            ok_d = 1'b0;
          end else begin
            tail_d  = tail_dec;
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          // query and unused codes leave pointers and count unchanged
        end
      endcase
    end
    // A capacity write empties the deque
    if (cfg_we_i) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= crd_pkg::CAP_RESET;
      eff_cap_q <= CNT_W'(EFF_RST);
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      ok_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q     <= cfg_cap_i;
        eff_cap_q <= eff_cap_d;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  assign cap_o = cap_q;

  // Ring store: front and rear read from the updated pointers
  crd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (value_i),
    .raddr_a_i (head_q),
    .raddr_b_i (tail_dec),
    .rdata_a_o (rd_front),
    .rdata_b_o (rd_rear)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      ok_o          <= ok_q;
      front_value_o <= is_empty_now ? '1 : rd_front;
      rear_value_o  <= is_empty_now ? '1 : rd_rear;
      is_empty_o    <= is_empty_now;
      is_full_o     <= is_full_now;
      count_o       <= count_q;
    end
  end

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= eff_cap_q)
    else $error("entry count above capacity");

  a_head_lt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(head_q) < eff_cap_q)
    else $error("head index beyond wrap point");

  a_tail_lt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(tail_q) < eff_cap_q)
    else $error("tail index beyond wrap point");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == eff_cap_q) |-> head_q == tail_q)
    else $error("pointers apart on empty or full deque");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> count_q == '0)
    else $error("capacity write did not empty the deque");
`endif

endmodule

>>> rtl/core/circular_deque_ring_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    cmd_i, value_i
// out       output     out_valid_o / out_ready_i  ok_o, front_value_o, rear_value_o,
//                                                 is_empty_o, is_full_o, count_o
// cfg       APB        psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each word runs through pointer update and store write, a registered read of
// the front and rear entries from the dual-read ring RAM, then the result load.
// A stalled output holds the result and the controller waits in its load step.
// Reset empties the deque and sets capacity to 16; the store itself is not cleared.
// A capacity write also empties the deque.

module circular_deque_ring_unit #(
  parameter int DEPTH      = crd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = crd_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crd_pkg::APB_AW-1:0]  paddr,
  input  logic [crd_pkg::APB_DW-1:0]  pwdata,
  output logic [crd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  cmd_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic signed [DATA_WIDTH-1:0] front_value_o,
  output logic signed [DATA_WIDTH-1:0] rear_value_o,
  output logic                        is_empty_o,
  output logic                        is_full_o,
  output logic [CNT_W-1:0]            count_o
);

  localparam int CAP_W = crd_pkg::CAP_W;
  localparam int AW    = crd_pkg::APB_AW;

  crd_pkg::dp_cmd_t  dp_cmd;
  logic              cfg_we;
  logic              reg_hit;
  logic [CAP_W-1:0]  cap;

  // Decode the register word index
  assign reg_hit = (paddr[AW-1:2] == crd_pkg::REG_CAPACITY);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? crd_pkg::APB_DW'(cap) : '0;

  crd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd)
  );

  crd_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .cfg_we_i      (cfg_we),
    .cfg_cap_i     (pwdata[CAP_W-1:0]),
    .cap_o         (cap),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .ok_o          (ok_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .count_o       (count_o)
  );

endmodule
